// ===== design/spo_pkg.sv =====
// shared types, constants and ring lookup for the stepper position tracker
`default_nettype none

package spo_pkg;

	localparam int NUM_MOTORS = 8;
	localparam int MOTOR_W    = $clog2(NUM_MOTORS);
	localparam int POS_W      = 9;
	localparam int PAT_W      = 4;

	localparam logic [POS_W-1:0] SPAN_REEL = 9'd96;
	localparam logic [POS_W-1:0] SPAN_DICE = 9'd288;

	// configuration register indexes
	localparam logic [1:0] REG_INDEX_START   = 2'd0;
	localparam logic [1:0] REG_INDEX_LENGTH  = 2'd1;
	localparam logic [1:0] REG_INDEX_PATTERN = 2'd2;
	localparam logic [1:0] REG_DICE_MASK     = 2'd3;

	localparam logic [0:0] REQ_UPDATE = 1'b0;
	localparam logic [0:0] REQ_RESET  = 1'b1;

	// marks a pattern that is not on the half-step ring
	localparam logic [3:0] RING_NONE = 4'd8;

	typedef struct packed {
		logic [PAT_W-1:0] cur;
		logic [PAT_W-1:0] prev;
		logic [POS_W-1:0] pos;
		logic             optic;
	} spo_entry_t;

	typedef struct packed {
		logic [POS_W-1:0]      index_start;
		logic [POS_W-1:0]      index_length;
		logic [PAT_W-1:0]      index_pattern;
		logic [NUM_MOTORS-1:0] dice_mask;
	} spo_cfg_t;

	// place of a coil pattern on the ring 1,9,8,A,2,6,4,5
	function automatic logic [3:0] ring_place(input logic [PAT_W-1:0] pat);
		logic [3:0] place;
		begin
			case (pat)
				4'h1:    place = 4'd0;
				4'h9:    place = 4'd1;
				4'h8:    place = 4'd2;
				4'hA:    place = 4'd3;
				4'h2:    place = 4'd4;
				4'h6:    place = 4'd5;
				4'h4:    place = 4'd6;
				4'h5:    place = 4'd7;
				default: place = RING_NONE;
			endcase
			return place;
		end
	endfunction

	function automatic logic signed [2:0] ring_delta(input logic [PAT_W-1:0] from_pat,
			input logic [PAT_W-1:0] to_pat);
		logic [3:0]        a;
		logic [3:0]        b;
		logic [2:0]        d;
		logic signed [2:0] res;
		begin
			a = ring_place(from_pat);
			b = ring_place(to_pat);
			d = b[2:0] - a[2:0];
			res = 3'sd0;
			if (!a[3] && !b[3]) begin
				case (d)
					3'd1:    res = 3'sd1;
					3'd2:    res = 3'sd2;
					3'd7:    res = -3'sd1;
					3'd6:    res = -3'sd2;
					default: res = 3'sd0;
				endcase
			end
			return res;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/spo_state_mem.sv =====
// per-motor state memory with valid bits and write-to-read forwarding
`default_nettype none

module spo_state_mem
	import spo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire logic [MOTOR_W-1:0] rd_addr,
	output spo_entry_t              rd_entry,
	input  wire logic               wr_en,
	input  wire logic [MOTOR_W-1:0] wr_addr,
	input  wire spo_entry_t         wr_entry
);

	spo_entry_t            mem [NUM_MOTORS];
	spo_entry_t            rd_data_q;
	logic                  rd_valid_q;
	logic [NUM_MOTORS-1:0] valid_q;
	logic                  fwd;

	assign fwd = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= fwd || valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			// a write to the same motor in this cycle wins over the stored word
			rd_data_q <= fwd ? wr_entry : mem[rd_addr];
		end
	end

	// never-written motors read as the all-zero reset state
	assign rd_entry = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== design/spo_update.sv =====
// step update: pattern history, ring delta, span wrap and optic window
`default_nettype none

module spo_update
	import spo_pkg::*;
(
	input  wire spo_cfg_t           cfg,
	input  wire logic               req_type,
	input  wire logic [MOTOR_W-1:0] motor,
	input  wire logic [PAT_W-1:0]   pattern,
	input  wire spo_entry_t         old_entry,
	output spo_entry_t              new_entry,
	output logic                    moved
);

	logic [PAT_W-1:0]   prev_next;
	logic signed [2:0]  delta;
	logic [POS_W-1:0]   span;
	logic signed [10:0] sum;
	logic signed [10:0] span_s;
	logic [POS_W-1:0]   pos_wrapped;
	logic [POS_W:0]     win_hi;
	spo_entry_t         cand;
	logic               pat_ok;
	logic               in_win;

	assign prev_next = (old_entry.cur != '0) ? old_entry.cur : old_entry.prev;
	assign delta     = ring_delta(prev_next, pattern);
	assign span      = cfg.dice_mask[motor] ? SPAN_DICE : SPAN_REEL;
	assign span_s    = $signed({2'b00, span});
	assign sum       = $signed({2'b00, old_entry.pos}) + $signed({{8{delta[2]}}, delta});

	always_comb begin
		if (sum > span_s) begin
			pos_wrapped = POS_W'(sum - span_s);
		end else if (sum < 11'sd0) begin
			pos_wrapped = POS_W'(sum + span_s);
		end else begin
			pos_wrapped = POS_W'(sum);
		end
	end

	assign win_hi = {1'b0, cfg.index_start} + {1'b0, cfg.index_length};

	always_comb begin
		cand       = old_entry;
		cand.optic = 1'b0;
		moved      = 1'b0;
		new_entry  = old_entry;
		if (req_type == REQ_RESET) begin
			cand      = '0;
			new_entry = cand;
		end else if (old_entry.cur != pattern) begin
			cand.cur  = pattern;
			cand.prev = prev_next;
			cand.pos  = pos_wrapped;
			new_entry = cand;
			new_entry.pos   = old_entry.pos;
			new_entry.optic = old_entry.optic;
			if (delta != 3'sd0) begin
				moved     = 1'b1;
				new_entry = cand;
			end
		end
		in_win = ({1'b0, cand.pos} >= {1'b0, cfg.index_start}) &&
			({1'b0, cand.pos} < win_hi);
		pat_ok = (cfg.index_pattern == '0) || (cand.cur == cfg.index_pattern) ||
			((cand.cur == '0) && (cand.prev == cfg.index_pattern));
		// optic is only refreshed on a reset request or an actual step
		if ((req_type == REQ_RESET) || moved) begin
			new_entry.optic = in_win && pat_ok;
		end
	end

endmodule

`default_nettype wire

// ===== design/stepper_position_and_index_optic.sv =====
// top level: request stage, state memory read-modify-write and result register
// a request waits in the request stage while its state memory read is registered,
// then the result register takes its update unless res_stall holds it; throughput:
// one request per cycle unless stalled, set by the single read-modify-write of the
// per-motor state memory, with a write-to-read bypass for the same motor
// reset: config registers return to defaults, memory valid bits clear so every
// motor reads as zero state at once (no clearing pass)
`default_nettype none

module stepper_position_and_index_optic
	import spo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [POS_W-1:0]   cfg_data,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               req_type,
	input  wire logic [MOTOR_W-1:0] motor_id,
	input  wire logic [PAT_W-1:0]   coil_pattern,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [MOTOR_W-1:0]      motor_out,
	output logic [POS_W-1:0]        step_position,
	output logic                    optic_lit,
	output logic                    moved
);

	spo_cfg_t           cfg_q;
	logic               v_s1;
	logic               req_type_s1;
	logic [MOTOR_W-1:0] motor_s1;
	logic [PAT_W-1:0]   pattern_s1;
	logic               res_valid_q;
	logic               accept;
	logic               advance;
	spo_entry_t         old_entry;
	spo_entry_t         new_entry;
	logic               moved_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_start   <= 9'd16;
			cfg_q.index_length  <= 9'd8;
			cfg_q.index_pattern <= 4'h9;
			cfg_q.dice_mask     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INDEX_START:   cfg_q.index_start   <= cfg_data;
				REG_INDEX_LENGTH:  cfg_q.index_length  <= cfg_data;
				REG_INDEX_PATTERN: cfg_q.index_pattern <= cfg_data[PAT_W-1:0];
				REG_DICE_MASK:     cfg_q.dice_mask     <= cfg_data[NUM_MOTORS-1:0];
				default: ;
			endcase
		end
	end

	assign advance   = v_s1 && (!res_valid_q || !res_stall);
	assign req_stall = v_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			motor_s1    <= motor_id;
			pattern_s1  <= coil_pattern;
		end
		if (advance) begin
			motor_out     <= motor_s1;
			step_position <= new_entry.pos;
			optic_lit     <= new_entry.optic;
			moved         <= moved_next;
		end
	end

	assign res_valid = res_valid_q;

	spo_state_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (motor_id),
		.rd_entry (old_entry),
		.wr_en    (advance),
		.wr_addr  (motor_s1),
		.wr_entry (new_entry)
	);

	spo_update u_update (
		.cfg       (cfg_q),
		.req_type  (req_type_s1),
		.motor     (motor_s1),
		.pattern   (pattern_s1),
		.old_entry (old_entry),
		.new_entry (new_entry),
		.moved     (moved_next)
	);

endmodule

`default_nettype wire
